### hdl/dogx_pkg.sv
// Shared types and constants for the DoG extremum detector.
// Used by dogx_line_buf, dogx_cmp and dog_extrema_detect; depends on nothing.
package dogx_pkg;

  // Layers per pixel: below, middle, above.
  localparam int LAYERS = 3;
  // Neighbours of a centre in a 3x3x3 window.
  localparam int NBRS = 26;

  localparam int MAX_WIDTH_DEF   = 1024;
  localparam int SAMPLE_BITS_DEF = 16;

  // Configuration register widths and the write port width.
  localparam int CFG_W_BITS    = 11;
  localparam int CFG_H_BITS    = 13;
  localparam int CFG_TAG_BITS  = 6;
  localparam int CFG_DATA_BITS = 13;
  localparam int CFG_IDX_BITS  = 2;

  // Row position and frame height.
  localparam int ROW_BITS   = 12;
  localparam int MIN_DIM    = 3;
  localparam int MAX_HEIGHT = 4096;

  localparam logic [CFG_W_BITS-1:0]   RST_IMAGE_WIDTH  = CFG_W_BITS'(640);
  localparam logic [CFG_H_BITS-1:0]   RST_IMAGE_HEIGHT = CFG_H_BITS'(480);
  localparam logic [CFG_TAG_BITS-1:0] RST_LAYER_TAG    = '0;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_IMAGE_WIDTH  = 2'd0,
    CFG_IMAGE_HEIGHT = 2'd1,
    CFG_LAYER_TAG    = 2'd2
  } dogx_cfg_e;

  // Outcome of the 26 comparisons for one centre.
  typedef struct packed {
    logic is_max;
    logic is_min;
  } dogx_flags_t;

endpackage

### hdl/dogx_line_buf.sv
// Two line stores holding the previous two image rows, three layers per column.
// Registered read port and one write port per store; uses dogx_pkg.
module dogx_line_buf import dogx_pkg::*; #(
  parameter int MAX_WIDTH   = MAX_WIDTH_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rd_en_i,
  input  logic [$clog2(MAX_WIDTH)-1:0]    rd_addr_i,
  output logic [LAYERS*SAMPLE_BITS-1:0]   rd_a_o,
  output logic [LAYERS*SAMPLE_BITS-1:0]   rd_b_o,
  input  logic                            wr_en_i,
  input  logic [$clog2(MAX_WIDTH)-1:0]    wr_addr_i,
  input  logic [LAYERS*SAMPLE_BITS-1:0]   wr_a_i,
  input  logic [LAYERS*SAMPLE_BITS-1:0]   wr_b_i
);

  logic [LAYERS*SAMPLE_BITS-1:0] mem_a [MAX_WIDTH];
  logic [LAYERS*SAMPLE_BITS-1:0] mem_b [MAX_WIDTH];
  logic [LAYERS*SAMPLE_BITS-1:0] rd_a_q;
  logic [LAYERS*SAMPLE_BITS-1:0] rd_b_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_a[wr_addr_i] <= wr_a_i;
      mem_b[wr_addr_i] <= wr_b_i;
    end
  end

  // A read of the entry written in the same cycle returns the new data, which
  // happens when a frame start follows an item in the first column.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      if (wr_en_i && (wr_addr_i == rd_addr_i)) begin
        rd_a_q <= wr_a_i;
        rd_b_q <= wr_b_i;
      end else begin
        rd_a_q <= mem_a[rd_addr_i];
        rd_b_q <= mem_b[rd_addr_i];
      end
    end
  end

  assign rd_a_o = rd_a_q;
  assign rd_b_o = rd_b_q;

endmodule

### hdl/dogx_cmp.sv
// Strict comparison of a centre value against its 26 window neighbours.
// Purely combinational; uses dogx_pkg for the flag struct.
module dogx_cmp import dogx_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic signed [SAMPLE_BITS-1:0] centre_i,
  input  logic signed [SAMPLE_BITS-1:0] nbr_i [NBRS],
  output dogx_flags_t                   flags_o
);

  logic [NBRS-1:0] above_all;
  logic [NBRS-1:0] below_all;

  always_comb begin
    for (int k = 0; k < NBRS; k++) begin
      above_all[k] = centre_i > nbr_i[k];
      below_all[k] = centre_i < nbr_i[k];
    end
  end

  assign flags_o.is_max = &above_all;
  assign flags_o.is_min = &below_all;

endmodule

### hdl/dog_extrema_detect.sv
// Top level of the 3x3x3 DoG extremum detector: position counters, window, output register.
// Instantiates dogx_line_buf and dogx_cmp; uses dogx_pkg.
//
//   Port group   Direction  Handshake              Payload
//   in           sink       in_valid_i/in_stall_o  frame_start, sample_below/center/above
//   out          source     out_valid_o/out_stall_i kp_row, kp_col, is_maximum, kp_layer
//   cfg          sink       cfg_we_i               cfg_idx_i, cfg_data_i
//
// One item is taken every cycle while in_stall_o is low. Taking a pixel reads both line
// stores at its column into the middle stage; advancing that stage compares the window
// and writes the line stores and the output register, where any keypoint then appears.
// Reset clears counters and window and loads the default configuration; the line stores are not cleared.
// An output stall holds the result and stalls the input only once the middle stage is full.
module dog_extrema_detect import dogx_pkg::*; #(
  parameter int MAX_WIDTH   = MAX_WIDTH_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          frame_start_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_below_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_center_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_above_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [ROW_BITS-1:0]           kp_row_o,
  output logic [$clog2(MAX_WIDTH)-1:0]  kp_col_o,
  output logic                          is_maximum_o,
  output logic [CFG_TAG_BITS-1:0]       kp_layer_o,
  input  logic                          cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]       cfg_idx_i,
  input  logic [CFG_DATA_BITS-1:0]      cfg_data_i
);

  localparam int ColW = $clog2(MAX_WIDTH);
  localparam int WW   = $clog2(MAX_WIDTH + 1);
  localparam int EW   = (WW > CFG_W_BITS) ? WW : CFG_W_BITS;
  localparam int SB   = SAMPLE_BITS;

  // Configuration.
  logic [CFG_W_BITS-1:0]   image_width_q;
  logic [CFG_H_BITS-1:0]   image_height_q;
  logic [CFG_TAG_BITS-1:0] layer_tag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_width_q  <= RST_IMAGE_WIDTH;
      image_height_q <= RST_IMAGE_HEIGHT;
      layer_tag_q    <= RST_LAYER_TAG;
    end else if (cfg_we_i) begin
      unique case (dogx_cfg_e'(cfg_idx_i))
        CFG_IMAGE_WIDTH:  image_width_q  <= cfg_data_i[CFG_W_BITS-1:0];
        CFG_IMAGE_HEIGHT: image_height_q <= cfg_data_i[CFG_H_BITS-1:0];
        CFG_LAYER_TAG:    layer_tag_q    <= cfg_data_i[CFG_TAG_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Frame size, saturated to the supported range.
  logic [EW-1:0]         width_ext;
  logic [WW-1:0]         width;
  logic [CFG_H_BITS-1:0] height;

  always_comb begin
    width_ext = EW'(image_width_q);
    if (width_ext < EW'(MIN_DIM)) begin
      width = WW'(MIN_DIM);
    end else if (width_ext > EW'(MAX_WIDTH)) begin
      width = WW'(MAX_WIDTH);
    end else begin
      width = width_ext[WW-1:0];
    end
    if (image_height_q < CFG_H_BITS'(MIN_DIM)) begin
      height = CFG_H_BITS'(MIN_DIM);
    end else if (image_height_q > CFG_H_BITS'(MAX_HEIGHT)) begin
      height = CFG_H_BITS'(MAX_HEIGHT);
    end else begin
      height = image_height_q;
    end
  end

  // Handshake and pipeline control.
  logic in_acc;
  logic adv;
  logic s1_valid_q;

  assign adv        = s1_valid_q && (!out_valid_o || !out_stall_i);
  assign in_stall_o = s1_valid_q && !adv;
  assign in_acc     = in_valid_i && !in_stall_o;

  // Position of the incoming pixel and of the next one.
  logic [ColW-1:0]       col_q, col_d, pix_col;
  logic [ROW_BITS-1:0]   row_q, row_d, pix_row;
  logic [ColW-1:0]       col_base;
  logic [ROW_BITS-1:0]   row_base;
  logic [CFG_H_BITS-1:0] row_wrap;
  logic [WW-1:0]         col_inc;
  logic [CFG_H_BITS-1:0] row_inc;

  always_comb begin
    col_base = frame_start_i ? '0 : col_q;
    row_base = frame_start_i ? '0 : row_q;
    // A column left past a shrunken width starts the next row.
    row_wrap = CFG_H_BITS'(row_base);
    pix_col  = col_base;
    if (WW'(col_base) >= width) begin
      pix_col  = '0;
      row_wrap = CFG_H_BITS'(row_base) + CFG_H_BITS'(1);
    end
    pix_row = (row_wrap >= height) ? '0 : row_wrap[ROW_BITS-1:0];

    col_inc = WW'(pix_col) + WW'(1);
    row_inc = CFG_H_BITS'(pix_row) + CFG_H_BITS'(1);
    col_d   = col_inc[ColW-1:0];
    row_d   = pix_row;
    if (col_inc >= width) begin
      col_d = '0;
      row_d = (row_inc >= height) ? '0 : row_inc[ROW_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (in_acc) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // Middle stage: the item whose line-store words are being read.
  logic [ColW-1:0]             s1_col_q;
  logic [ROW_BITS-1:0]         s1_row_q;
  logic [LAYERS-1:0][SB-1:0]   s1_samp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
    end else if (adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_col_q     <= pix_col;
      s1_row_q     <= pix_row;
      s1_samp_q[0] <= sample_below_i;
      s1_samp_q[1] <= sample_center_i;
      s1_samp_q[2] <= sample_above_i;
    end
  end

  logic [LAYERS-1:0][SB-1:0] rd_a;
  logic [LAYERS-1:0][SB-1:0] rd_b;

  dogx_line_buf #(
    .MAX_WIDTH  (MAX_WIDTH),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_line_buf (
    .clk_i    (clk_i),
    .rd_en_i  (in_acc),
    .rd_addr_i(pix_col),
    .rd_a_o   (rd_a),
    .rd_b_o   (rd_b),
    .wr_en_i  (adv),
    .wr_addr_i(s1_col_q),
    .wr_a_i   (rd_b),
    .wr_b_i   (s1_samp_q)
  );

  // Window: two previous columns plus the column just completed.
  logic signed [SB-1:0] win_q [2][3][LAYERS];
  logic signed [SB-1:0] cur [3][LAYERS];
  logic signed [SB-1:0] nbr [NBRS];
  int                   k;

  always_comb begin
    for (int l = 0; l < LAYERS; l++) begin
      cur[0][l] = $signed(rd_a[l]);
      cur[1][l] = $signed(rd_b[l]);
      cur[2][l] = $signed(s1_samp_q[l]);
    end
  end

  always_comb begin
    k = 0;
    for (int l = 0; l < NBRS; l++) begin
      nbr[l] = '0;
    end
    for (int x = 0; x < 3; x++) begin
      for (int y = 0; y < 3; y++) begin
        for (int l = 0; l < LAYERS; l++) begin
          if (!(x == 1 && y == 1 && l == 1)) begin
            nbr[k] = (x < 2) ? win_q[x][y][l] : cur[y][l];
            k = k + 1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int x = 0; x < 2; x++) begin
        for (int y = 0; y < 3; y++) begin
          for (int l = 0; l < LAYERS; l++) begin
            win_q[x][y][l] <= '0;
          end
        end
      end
    end else if (adv) begin
      win_q[0] <= win_q[1];
      win_q[1] <= cur;
    end
  end

  dogx_flags_t flags;

  dogx_cmp #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_cmp (
    .centre_i(win_q[1][1][1]),
    .nbr_i   (nbr),
    .flags_o (flags)
  );

  // Border centres never qualify.
  logic s1_hit;
  assign s1_hit = (s1_row_q >= ROW_BITS'(2)) && (s1_col_q >= ColW'(2)) &&
                  (flags.is_max || flags.is_min);

  // Output register.
  logic                    out_valid_q;
  logic [ROW_BITS-1:0]     kp_row_q;
  logic [ColW-1:0]         kp_col_q;
  logic                    is_max_q;
  logic [CFG_TAG_BITS-1:0] kp_layer_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= s1_hit;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s1_hit) begin
      kp_row_q   <= s1_row_q - ROW_BITS'(1);
      kp_col_q   <= s1_col_q - ColW'(1);
      is_max_q   <= flags.is_max;
      kp_layer_q <= layer_tag_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign kp_row_o     = kp_row_q;
  assign kp_col_o     = kp_col_q;
  assign is_maximum_o = is_max_q;
  assign kp_layer_o   = kp_layer_q;

  // A reported keypoint always lies inside the border.
  a_kp_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (kp_row_o != '0) && (kp_col_o != '0))
    else $error("keypoint reported on the image border");

  // A held middle-stage item keeps its column until it moves on.
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !adv) |=> (s1_valid_q && $stable(s1_col_q)))
    else $error("middle-stage item lost while stalled");

  // A stalled result with a full middle stage must stall the input.
  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && out_valid_o && out_stall_i) |-> in_stall_o)
    else $error("input taken while pipeline is full");

  // A result is never both a maximum and a minimum.
  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && s1_hit) |-> !(flags.is_max && flags.is_min))
    else $error("centre flagged as maximum and minimum");

endmodule

### tb/dog_extrema_detect_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for dog_extrema_detect: paced DoG pixel items in, keypoints out.
// Keypoints are predicted by a behavioral 3x3x3 extremum model kept in this file.
// Depends on dogx_pkg and the dog_extrema_detect RTL.
module dog_extrema_detect_tb;
  import dogx_pkg::*;

  localparam int COL_BITS = $clog2(MAX_WIDTH_DEF);
  localparam int SETTLE_CYCLES = 8;
  localparam int LONG_HOLD = 120;
  localparam int unsigned CYCLE_LIMIT = 5_000_000;

  typedef bit signed [SAMPLE_BITS_DEF-1:0] sample_t;

  typedef struct packed {
    logic [ROW_BITS-1:0]     row;
    logic [COL_BITS-1:0]     col;
    logic                    is_max;
    logic [CFG_TAG_BITS-1:0] layer;
  } keypoint_t;

  typedef struct packed {
    logic                              fs;
    logic signed [SAMPLE_BITS_DEF-1:0] below, mid, above;
    logic                              hit;
    keypoint_t                         kp;
  } probe_t;

  typedef enum {GEN_PEAKS, GEN_NOISE, GEN_TIES, GEN_RAILS} gen_mode_e;

  localparam logic signed [15:0] RAIL_LO = 16'sh8000;
  localparam logic signed [15:0] RAIL_HI = 16'sh7FFF;
  localparam logic signed [15:0] NEAR_LO = 16'sh8001;
  localparam logic signed [15:0] NEAR_HI = 16'sh7FFE;

  // Two 3x3 frames with a layer tag of 63. The first has a strict maximum at the
  // center against neighbours that include rail and near-rail values; the second follows
  // without a frame start, relying on the wrap at the end of the frame, and has a strict minimum there.
  localparam probe_t PROBES [18] = '{
    '{1'b1, RAIL_LO,    16'sd0,     NEAR_HI,    1'b0, '0},
    '{1'b0, 16'sd0,     -16'sd1,    RAIL_LO,    1'b0, '0},
    '{1'b0, 16'sd100,   16'sd200,   16'sd300,   1'b0, '0},
    '{1'b0, -16'sd5,    NEAR_HI,    16'sd7,     1'b0, '0},
    '{1'b0, NEAR_HI,    RAIL_HI,    NEAR_HI,    1'b0, '0},
    '{1'b0, NEAR_HI,    RAIL_LO,    16'sd0,     1'b0, '0},
    '{1'b0, 16'sd1,     16'sd2,     16'sd3,     1'b0, '0},
    '{1'b0, RAIL_LO,    RAIL_LO,    RAIL_LO,    1'b0, '0},
    '{1'b0, NEAR_HI,    NEAR_HI,    NEAR_HI,    1'b1, '{12'd1, 10'd1, 1'b1, 6'd63}},
    '{1'b0, NEAR_LO,    16'sd0,     RAIL_HI,    1'b0, '0},
    '{1'b0, RAIL_HI,    RAIL_HI,    RAIL_HI,    1'b0, '0},
    '{1'b0, -16'sd1,    -16'sd1,    -16'sd1,    1'b0, '0},
    '{1'b0, 16'sd5,     NEAR_LO,    16'sd9,     1'b0, '0},
    '{1'b0, NEAR_LO,    RAIL_LO,    NEAR_LO,    1'b0, '0},
    '{1'b0, 16'sd0,     16'sd0,     16'sd0,     1'b0, '0},
    '{1'b0, RAIL_HI,    NEAR_LO,    16'sd1,     1'b0, '0},
    '{1'b0, -16'sd2,    16'sd3,     -16'sd4,    1'b0, '0},
    '{1'b0, 16'sd1000,  -16'sd1000, 16'sd1000,  1'b1, '{12'd1, 10'd1, 1'b0, 6'd63}}
  };

  logic                              clk_i;
  logic                              rst_ni;
  logic                              in_valid_i;
  logic                              in_stall_o;
  logic                              frame_start_i;
  logic signed [SAMPLE_BITS_DEF-1:0] sample_below_i;
  logic signed [SAMPLE_BITS_DEF-1:0] sample_center_i;
  logic signed [SAMPLE_BITS_DEF-1:0] sample_above_i;
  logic                              out_valid_o;
  logic                              out_stall_i;
  logic [ROW_BITS-1:0]               kp_row_o;
  logic [COL_BITS-1:0]               kp_col_o;
  logic                              is_maximum_o;
  logic [CFG_TAG_BITS-1:0]           kp_layer_o;
  logic                              cfg_we_i;
  logic [CFG_IDX_BITS-1:0]           cfg_idx_i;
  logic [CFG_DATA_BITS-1:0]          cfg_data_i;

  dog_extrema_detect DUT (.*);

  // Predictor copy of the configuration and of the window state.
  logic [CFG_W_BITS-1:0]   width_reg  = RST_IMAGE_WIDTH;
  logic [CFG_H_BITS-1:0]   height_reg = RST_IMAGE_HEIGHT;
  logic [CFG_TAG_BITS-1:0] tag_reg    = RST_LAYER_TAG;
  sample_t     store_old  [MAX_WIDTH_DEF][LAYERS];
  sample_t     store_prev [MAX_WIDTH_DEF][LAYERS];
  sample_t     win_cols   [2][3][LAYERS];
  int unsigned row_pos = 0;
  int unsigned col_pos = 0;

  keypoint_t   keypoint_q [$];
  int unsigned mismatch_count = 0;
  bit          long_hold_req = 1'b0;
  int unsigned calm_items = 0;
  gen_mode_e   gen_mode = GEN_NOISE;
  int unsigned seg_left = 0;
  bit          peak_up, par_r, par_c;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin : watchdog
    int unsigned cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("dog_extrema_detect: mismatch");
    $finish;
  end

  // Appends a keypoint to the list of expected results.
  function automatic void queue_keypoint(keypoint_t kp);
    keypoint_q.insert(keypoint_q.size(), kp);
  endfunction

  function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
    if (v < MIN_DIM) return MIN_DIM;
    return (v > hi) ? hi : v;
  endfunction

  // Position of the next pixel, with frame start and the lazy wraps applied.
  function automatic void locate_pixel(input logic fs, output int unsigned r,
                                       output int unsigned c);
    r = row_pos;
    c = col_pos;
    if (fs) begin
      r = 0;
      c = 0;
    end
    if (c >= clamp_dim(width_reg, MAX_WIDTH_DEF)) begin
      c = 0;
      r++;
    end
    if (r >= clamp_dim(height_reg, MAX_HEIGHT)) r = 0;
  endfunction

  // Consumes one pixel; returns 1 when it completes a window whose center is a
  // strict extremum against all 26 neighbours.
  function automatic bit detect_extremum(input logic fs, input sample_t below,
                                         input sample_t mid, input sample_t above,
                                         output keypoint_t kp);
    int unsigned r, c;
    int x, y, l;
    sample_t fresh [LAYERS];
    sample_t col_now [3][LAYERS];
    sample_t centre, v;
    bit up, down;
    locate_pixel(fs, r, c);
    fresh[0] = below;
    fresh[1] = mid;
    fresh[2] = above;
    for (l = 0; l < LAYERS; l++) begin
      col_now[0][l] = store_old[c][l];
      col_now[1][l] = store_prev[c][l];
      col_now[2][l] = fresh[l];
      store_old[c][l] = store_prev[c][l];
      store_prev[c][l] = fresh[l];
    end
    up = 1'b0;
    down = 1'b0;
    kp = '0;
    if (r >= 2 && c >= 2) begin
      centre = win_cols[1][1][1];
      up = 1'b1;
      down = 1'b1;
      for (x = 0; x < 3; x++)
        for (y = 0; y < 3; y++)
          for (l = 0; l < LAYERS; l++) begin
            if (!(x == 1 && y == 1 && l == 1)) begin
              v = (x < 2) ? win_cols[x][y][l] : col_now[y][l];
              if (v >= centre) up = 1'b0;
              if (v <= centre) down = 1'b0;
            end
          end
      if (up || down) begin
        kp.row = ROW_BITS'(r - 1);
        kp.col = COL_BITS'(c - 1);
        kp.is_max = up;
        kp.layer = tag_reg;
      end
    end
    for (y = 0; y < 3; y++)
      for (l = 0; l < LAYERS; l++) begin
        win_cols[0][y][l] = win_cols[1][y][l];
        win_cols[1][y][l] = col_now[y][l];
      end
    row_pos = r;
    col_pos = c + 1;
    if (col_pos >= clamp_dim(width_reg, MAX_WIDTH_DEF)) begin
      col_pos = 0;
      row_pos = r + 1;
      if (row_pos >= clamp_dim(height_reg, MAX_HEIGHT)) row_pos = 0;
    end
    return up || down;
  endfunction

  // Mostly short idle stretches, now and then a long one.
  function automatic int unsigned idle_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
  endfunction

  // In peak mode the pixels of one row/column parity stand out in the middle
  // layer, so each of them is a strict extremum of its neighbourhood.
  function automatic sample_t gen_sample(bit hot);
    int v;
    case (gen_mode)
      GEN_PEAKS: begin
        if (hot) v = peak_up ? int'($urandom_range(1000, 32767))
                             : -int'($urandom_range(1001, 32768));
        else v = peak_up ? int'($urandom_range(0, 33767)) - 32768
                         : 32767 - int'($urandom_range(0, 33767));
      end
      GEN_TIES: v = int'($urandom_range(0, 4)) - 2;
      GEN_RAILS: begin
        case ($urandom_range(0, 3))
          0: v = -32768;
          1: v = 32767;
          2: v = 0;
          default: v = -1;
        endcase
      end
      default: v = int'($urandom());
    endcase
    return sample_t'(v);
  endfunction

  task automatic send_pixel(input logic fs, input sample_t below, input sample_t mid,
                            input sample_t above);
    int unsigned gap;
    if (calm_items != 0) begin
      calm_items--;
      gap = 0;
    end else if ($urandom_range(0, 31) == 0) begin
      calm_items = $urandom_range(20, 100);
      gap = 0;
    end else begin
      gap = ($urandom_range(0, 2) == 0) ? idle_len() : 0;
    end
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    frame_start_i   <= fs;
    sample_below_i  <= below;
    sample_center_i <= mid;
    sample_above_i  <= above;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
  endtask

  task automatic program_regs(int unsigned w, int unsigned h, int unsigned tag);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_IMAGE_WIDTH;
    cfg_data_i <= CFG_DATA_BITS'(w);
    @(posedge clk_i);
    cfg_idx_i  <= CFG_IMAGE_HEIGHT;
    cfg_data_i <= CFG_DATA_BITS'(h);
    @(posedge clk_i);
    cfg_idx_i  <= CFG_LAYER_TAG;
    cfg_data_i <= CFG_DATA_BITS'(tag);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    width_reg  = CFG_W_BITS'(w);
    height_reg = CFG_H_BITS'(h);
    tag_reg    = CFG_TAG_BITS'(tag);
  endtask

  // Waits for every predicted keypoint, then lets the pipeline empty out.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (keypoint_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // The caller must request a restart whenever the width grows, so that no line store entry
  // is read before the current frame has written it; run_phase itself does not force it.
  task automatic run_phase(int unsigned w, int unsigned h, int unsigned tag,
                           int unsigned count, bit restart, bit noisy, bit squeeze);
    logic fs;
    int unsigned r, c, i, pick;
    sample_t b, m, a;
    keypoint_t kp;
    program_regs(w, h, tag);
    if (squeeze) begin
      gen_mode = GEN_PEAKS;
      seg_left = 150;
      peak_up = 1'b1;
      par_r = 1'b1;
      par_c = 1'b1;
      long_hold_req = 1'b1;
    end
    for (i = 0; i < count; i++) begin
      if (seg_left == 0) begin
        pick = $urandom_range(0, 19);
        if (pick < 9) gen_mode = GEN_PEAKS;
        else if (pick < 15) gen_mode = GEN_NOISE;
        else if (pick < 18) gen_mode = GEN_TIES;
        else gen_mode = GEN_RAILS;
        seg_left = $urandom_range(20, 60);
        peak_up = $urandom_range(0, 1);
        par_r = $urandom_range(0, 1);
        par_c = $urandom_range(0, 1);
      end
      seg_left--;
      fs = (i == 0) ? restart : (noisy && $urandom_range(0, 63) == 0);
      locate_pixel(fs, r, c);
      b = gen_sample(1'b0);
      m = gen_sample(r[0] == par_r && c[0] == par_c);
      a = gen_sample(1'b0);
      send_pixel(fs, b, m, a);
      if (detect_extremum(fs, b, m, a, kp)) queue_keypoint(kp);
    end
    settle();
  endtask

  initial begin : stimulus
    keypoint_t kp;
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    frame_start_i   = 1'b0;
    sample_below_i  = '0;
    sample_center_i = '0;
    sample_above_i  = '0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = CFG_IMAGE_WIDTH;
    cfg_data_i      = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    program_regs(3, 3, 63);
    foreach (PROBES[k]) begin
      send_pixel(PROBES[k].fs, PROBES[k].below, PROBES[k].mid, PROBES[k].above);
      void'(detect_extremum(PROBES[k].fs, PROBES[k].below, PROBES[k].mid,
                            PROBES[k].above, kp));
      if (PROBES[k].hit) queue_keypoint(PROBES[k].kp);
    end
    settle();

    // Sizes below the minimum saturate to 3x3.
    run_phase(0, 0, 0, 50, 1'b0, 1'b1, 1'b0);
    run_phase(8, 6, 21, 110, 1'b1, 1'b1, 1'b1);
    // Shrinks without a restart: the column and row counters can fall outside the new size.
    run_phase(4, 3, 42, 60, 1'b0, 1'b1, 1'b0);
    // Oversized values saturate.
    run_phase(2047, 3, 63, 60, 1'b1, 1'b0, 1'b0);
    run_phase(3, 8191, 1, 60, 1'b1, 1'b0, 1'b0);
    run_phase(6, 4, 10, 100, 1'b1, 1'b1, 1'b1);

    if (mismatch_count == 0) $display("dog_extrema_detect: match");
    else $display("dog_extrema_detect: mismatch");
    $finish;
  end

  initial begin : stall_gen
    int unsigned stall_left, free_left;
    stall_left = 0;
    free_left = 0;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        stall_left = LONG_HOLD;
        free_left = 0;
      end
      if (stall_left != 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
        if (free_left != 0) begin
          free_left--;
        end else if ($urandom_range(0, 7) == 0) begin
          free_left = $urandom_range(30, 200);
        end else begin
          free_left = $urandom_range(0, 6);
          stall_left = idle_len();
        end
      end
    end
  end

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  initial begin : kp_checker
    keypoint_t want;
    forever begin
      @(posedge clk_i);
      if (out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
        if (keypoint_q.size() == 0) begin
          $display("%0t: keypoint expected none, actual row %0d col %0d max %0d layer %0d",
                   $time, kp_row_o, kp_col_o, is_maximum_o, kp_layer_o);
          mismatch_count++;
        end else begin
          want = keypoint_q.pop_front();
          check_field("kp_row", want.row, kp_row_o);
          check_field("kp_col", want.col, kp_col_o);
          check_field("is_maximum", want.is_max, is_maximum_o);
          check_field("kp_layer", want.layer, kp_layer_o);
        end
      end
    end
  end

endmodule
